[hdl/gcpb_pkg.sv]
// Shared types, register codes, reset values and arithmetic helpers for the
// glyph coverage pixel blend. No dependencies.
package gcpb_pkg;

    localparam int NSTG    = 8;
    localparam int DIV_STG = 4;
    localparam int COV_STG = DIV_STG + 1;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 24;

    localparam logic [CFG_IW-1:0] REG_PIXEL_MODE  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_GRAY_LEVELS = 2'd1;
    localparam logic [CFG_IW-1:0] REG_TEXT_RGB    = 2'd2;
    localparam logic [CFG_IW-1:0] REG_OUT_ALPHA   = 2'd3;

    localparam logic [1:0] MODE_MONO = 2'd0;
    localparam logic [1:0] MODE_GRAY = 2'd1;

    localparam logic [1:0]  RST_PIXEL_MODE  = MODE_GRAY;
    localparam logic [8:0]  RST_GRAY_LEVELS = 9'd256;
    localparam logic [23:0] RST_TEXT_RGB    = 24'hE6E6E6;
    localparam logic [7:0]  RST_OUT_ALPHA   = 8'hE8;

    localparam logic [7:0]  COV_FULL     = 8'hFF;
    localparam logic [7:0]  ROUND_HALF   = 8'd127;
    localparam logic [16:0] DIV255_RECIP = 17'h08081;

    typedef logic [NSTG-1:0] t_stage_en;

    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] levels;
    } t_cov_cfg;

    typedef struct packed {
        logic        take;
        logic [15:0] rem;
    } t_div_step;

    function automatic t_div_step div_step(input logic [15:0] rem, input logic [8:0] den,
                                           input logic [2:0] sh);
        logic [16:0] sd;
        logic [16:0] r17;
        t_div_step   res;
        sd  = {8'd0, den} << sh;
        r17 = {1'b0, rem};
        if (r17 >= sd) begin
            res.take = 1'b1;
            res.rem  = 16'(r17 - sd);
        end else begin
            res.take = 1'b0;
            res.rem  = rem;
        end
        return res;
    endfunction

endpackage

[hdl/gcpb_if.sv]
// Valid/ready channel interfaces for pixel input and blended pixel output.
// No dependencies.
interface gcpb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  src_byte;
    logic [2:0]  bit_index;
    logic [31:0] dest_pixel;

    modport source(output valid, output src_byte, output bit_index, output dest_pixel,
                   input ready);
    modport sink(input valid, input src_byte, input bit_index, input dest_pixel,
                 output ready);
endinterface

interface gcpb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;

    modport source(output valid, output out_pixel, input ready);
    modport sink(input valid, input out_pixel, output ready);
endinterface

[hdl/glyph_coverage_pixel_blend.sv]
// Glyph coverage pixel blend, ARGB8888: top level with configuration registers
// and pipeline flow control. Uses gcpb_pkg, gcpb_if, gcpb_coverage, gcpb_lane, gcpb_merge.
//
// The block takes one pixel per clock unless the output stalls with all stages full, and
// passes each blended pixel through five coverage stages (mode decode plus a four-stage
// gray divider), two stages in each of the three color lanes, and the output
// register. Every stage moves on when the one after it is empty or moving, so
// a stalled output only stops intake once all eight stages hold a pixel.
// Configuration writes take effect at once and are meant for an empty pipeline.
module glyph_coverage_pixel_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    gcpb_in_if.sink                    i_px,
    gcpb_out_if.source                 o_px,
    input  logic                       i_cfg_we,
    input  logic [gcpb_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [gcpb_pkg::CFG_DW-1:0] i_cfg_data
);
    import gcpb_pkg::*;

    logic [1:0]  r_mode;
    logic [8:0]  r_levels;
    logic [23:0] r_rgb;
    logic [7:0]  r_alpha;

    t_stage_en   r_vld;
    t_stage_en   n_vld;
    t_stage_en   ld;
    t_cov_cfg    cov_cfg;
    logic        full;

    logic [7:0]  cov;
    logic [31:0] cov_dest;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_PIXEL_MODE;
            r_levels <= RST_GRAY_LEVELS;
            r_rgb    <= RST_TEXT_RGB;
            r_alpha  <= RST_OUT_ALPHA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PIXEL_MODE:  r_mode   <= i_cfg_data[1:0];
                REG_GRAY_LEVELS: r_levels <= i_cfg_data[8:0];
                REG_TEXT_RGB:    r_rgb    <= i_cfg_data[23:0];
                REG_OUT_ALPHA:   r_alpha  <= i_cfg_data[7:0];
                default:         r_alpha  <= r_alpha;
            endcase
        end
    end

    always_comb begin
        full = 1'b1;
        ld   = '0;
        for (int i = NSTG - 1; i >= 0; i--) begin
            full  = full & r_vld[i];
            ld[i] = !full || o_px.ready;
        end
    end

    assign n_vld = {r_vld[NSTG-2:0], i_px.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (ld & n_vld) | (~ld & r_vld);
        end
    end

    assign i_px.ready = ld[0];
    assign o_px.valid = r_vld[NSTG-1];

    assign cov_cfg.mode   = r_mode;
    assign cov_cfg.levels = r_levels;

    gcpb_coverage u_coverage (
        .i_clk  (i_clk),
        .i_en   (ld[COV_STG-1:0]),
        .i_cfg  (cov_cfg),
        .i_byte (i_px.src_byte),
        .i_bit  (i_px.bit_index),
        .i_dest (i_px.dest_pixel),
        .o_cov  (cov),
        .o_dest (cov_dest)
    );

    gcpb_lane u_lane_r (
        .i_clk (i_clk),
        .i_en  (ld[COV_STG+1:COV_STG]),
        .i_src (r_rgb[23:16]),
        .i_dst (cov_dest[23:16]),
        .i_cov (cov),
        .o_val (red)
    );

    gcpb_lane u_lane_g (
        .i_clk (i_clk),
        .i_en  (ld[COV_STG+1:COV_STG]),
        .i_src (r_rgb[15:8]),
        .i_dst (cov_dest[15:8]),
        .i_cov (cov),
        .o_val (green)
    );

    gcpb_lane u_lane_b (
        .i_clk (i_clk),
        .i_en  (ld[COV_STG+1:COV_STG]),
        .i_src (r_rgb[7:0]),
        .i_dst (cov_dest[7:0]),
        .i_cov (cov),
        .o_val (blue)
    );

    gcpb_merge u_merge (
        .i_clk      (i_clk),
        .i_en       (ld[NSTG-1:COV_STG]),
        .i_dest     (cov_dest),
        .i_cov_zero (cov == 8'd0),
        .i_alpha    (r_alpha),
        .i_red      (red),
        .i_green    (green),
        .i_blue     (blue),
        .o_pixel    (o_px.out_pixel)
    );

endmodule

[hdl/gcpb_coverage.sv]
// Coverage unit: mode decode and cap check, then a four-stage restoring
// divider for gray bitmaps, two quotient bits per stage. Uses gcpb_pkg.
module gcpb_coverage (
    input  logic                     i_clk,
    input  logic [gcpb_pkg::COV_STG-1:0] i_en,
    input  gcpb_pkg::t_cov_cfg       i_cfg,
    input  logic [7:0]               i_byte,
    input  logic [2:0]               i_bit,
    input  logic [31:0]              i_dest,
    output logic [7:0]               o_cov,
    output logic [31:0]              o_dest
);
    import gcpb_pkg::*;

    logic [15:0] num;
    logic [8:0]  den;
    logic        mono_bit;
    logic [7:0]  n_c;
    logic        n_div;

    logic [7:0]  r_c    [0:DIV_STG];
    logic        r_div  [0:DIV_STG];
    logic [15:0] r_rem  [0:DIV_STG];
    logic [31:0] r_dest [0:DIV_STG];

    assign num      = {i_byte, 8'd0} - {8'd0, i_byte};
    assign den      = i_cfg.levels - 9'd1;
    assign mono_bit = i_byte[3'd7 - i_bit];

    always_comb begin
        n_c   = '0;
        n_div = 1'b0;
        unique case (i_cfg.mode)
            MODE_MONO: begin
                n_c = mono_bit ? COV_FULL : 8'd0;
            end
            MODE_GRAY: begin
                if (i_cfg.levels > 9'd1) begin
                    if ({1'b0, num} >= {den, 8'd0}) begin
                        n_c = COV_FULL;
                    end else begin
                        n_div = 1'b1;
                    end
                end else begin
                    n_c = (i_byte != 8'd0) ? COV_FULL : 8'd0;
                end
            end
            default: begin
                n_c = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_c[0]    <= n_c;
            r_div[0]  <= n_div;
            r_rem[0]  <= num;
            r_dest[0] <= i_dest;
        end
    end

    for (genvar j = 1; j <= DIV_STG; j++) begin : g_div
        localparam int SH_HI = 9 - 2 * j;
        localparam int SH_LO = 8 - 2 * j;
        t_div_step  s_hi;
        t_div_step  s_lo;
        logic [7:0] q;

        always_comb begin
            s_hi = div_step(r_rem[j-1], den, 3'(SH_HI));
            s_lo = div_step(s_hi.rem, den, 3'(SH_LO));
            q    = r_c[j-1];
            if (r_div[j-1]) begin
                q[SH_HI] = s_hi.take;
                q[SH_LO] = s_lo.take;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_c[j]    <= q;
                r_div[j]  <= r_div[j-1];
                r_rem[j]  <= s_lo.rem;
                r_dest[j] <= r_dest[j-1];
            end
        end
    end

    assign o_cov  = r_c[DIV_STG];
    assign o_dest = r_dest[DIV_STG];

endmodule

[hdl/gcpb_lane.sv]
// One color channel lane: weighted products, then rounded divide by 255
// through a reciprocal multiply. Uses gcpb_pkg.
module gcpb_lane (
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  logic [7:0] i_src,
    input  logic [7:0] i_dst,
    input  logic [7:0] i_cov,
    output logic [7:0] o_val
);
    import gcpb_pkg::*;

    logic [15:0] r_ps;
    logic [15:0] r_pd;
    logic [7:0]  r_q;
    logic [16:0] sum;
    logic [33:0] prod;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ps <= {8'd0, i_src} * {8'd0, i_cov};
            r_pd <= {8'd0, i_dst} * {8'd0, COV_FULL - i_cov};
        end
    end

    assign sum  = {1'b0, r_ps} + {1'b0, r_pd} + {9'd0, ROUND_HALF};
    assign prod = {17'd0, sum} * {17'd0, DIV255_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_q <= prod[30:23];
        end
    end

    assign o_val = r_q;

endmodule

[hdl/gcpb_merge.sv]
// Merge stage: carries the destination pixel beside the lanes and forms the
// output pixel register from lane results or pass-through. Uses gcpb_pkg.
module gcpb_merge (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [31:0] i_dest,
    input  logic        i_cov_zero,
    input  logic [7:0]  i_alpha,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic [31:0] o_pixel
);
    import gcpb_pkg::*;

    logic [31:0] r_dest_a;
    logic        r_zero_a;
    logic [31:0] r_dest_b;
    logic        r_zero_b;
    logic [31:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dest_a <= i_dest;
            r_zero_a <= i_cov_zero;
        end
        if (i_en[1]) begin
            r_dest_b <= r_dest_a;
            r_zero_b <= r_zero_a;
        end
        if (i_en[2]) begin
            r_pix <= r_zero_b ? r_dest_b : {i_alpha, i_red, i_green, i_blue};
        end
    end

    assign o_pixel = r_pix;

endmodule

[hdl/gcpb_checker.sv]
// Port-level checks on the pixel blend top level, bound to every instance.
// Uses gcpb_pkg; attaches to glyph_coverage_pixel_blend.
module gcpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_pixel
);
    import gcpb_pkg::*;

    localparam int CW = $clog2(NSTG + 1);

    logic [CW-1:0] r_cnt;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(in_acc) - CW'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel))
        else $error("output transaction dropped or changed while stalled");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("intake stalled while output drains");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("output transaction without a pending input");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NSTG))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind glyph_coverage_pixel_blend gcpb_checker u_gcpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_px.valid),
    .i_in_ready  (i_px.ready),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_out_pixel (o_px.out_pixel)
);
